// ===== rtl/montgomery_modular_add_sub_unit_defines.svh =====
// assertion macros shared by the checker of the modular add/sub unit
`ifndef MONTGOMERY_MODULAR_ADD_SUB_UNIT_DEFINES_SVH
`define MONTGOMERY_MODULAR_ADD_SUB_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MMAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular add/sub check failed");

// antecedent implies consequent in the next cycle
`define MMAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular add/sub check failed");

`endif

// ===== rtl/mmas_pkg.sv =====
// package with types and constants of the modular add/sub unit
`default_nettype none

package mmas_pkg;

  // default sizes
  localparam int WordBitsDef = 32;
  localparam int MaxWordsDef = 32;

  // fixed field widths
  localparam int FieldWordW = 32;
  localparam int IndexW     = 5;
  localparam int CountW     = 6;

  localparam logic [CountW-1:0] WordCountRst = 6'd32;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_SUB  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_PASS1,
    ST_PASS2
  } state_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [IndexW-1:0]     word_index;
    logic [FieldWordW-1:0] a_word;
    logic [FieldWordW-1:0] b_word;
    logic [FieldWordW-1:0] r1_word;
  } in_item_t;

  typedef struct packed {
    logic [FieldWordW-1:0] result_word;
    logic [IndexW-1:0]     result_index;
    logic                  last;
  } out_item_t;

  // write strobes from the sequencer to the word stores
  typedef struct packed {
    logic load_we;
    logic part_we;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/mmas_alu.sv =====
// shared word adder/subtractor with a two-bit carry or borrow count
`default_nettype none

module mmas_alu #(
  parameter int WORD_BITS = mmas_pkg::WordBitsDef
) (
  input  wire logic [WORD_BITS-1:0] x_i,
  input  wire logic [WORD_BITS-1:0] y_i,
  input  wire logic [WORD_BITS-1:0] z_i,
  input  wire logic [1:0]           cin_i,
  input  wire logic                 sub_i,
  output logic      [WORD_BITS-1:0] word_o,
  output logic      [1:0]           cnt_o
);

  logic [WORD_BITS+2:0] addend;
  logic [WORD_BITS+2:0] total;
  logic [2:0]           hi;

  // x +/- (y + z + cin), wraps counted from the bits above the word
  always_comb begin
    addend = {3'b000, y_i} + {3'b000, z_i} + (WORD_BITS+3)'(cin_i);
    if (sub_i) begin
      total = {3'b000, x_i} - addend;
    end else begin
      total = {3'b000, x_i} + addend;
    end
    hi     = total[WORD_BITS+2:WORD_BITS];
    word_o = total[WORD_BITS-1:0];
    if (sub_i) begin
      cnt_o = 2'(3'd0 - hi);
    end else begin
      cnt_o = hi[1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmas_store.sv =====
// operand, montgomery one and partial result word memories
`default_nettype none

module mmas_store #(
  parameter int WORD_BITS = mmas_pkg::WordBitsDef,
  parameter int MAX_WORDS = mmas_pkg::MaxWordsDef,
  parameter int AW        = 5
) (
  input  wire logic                 clk_i,
  input  wire mmas_pkg::mem_ctrl_t  ctrl_i,
  input  wire logic [AW-1:0]        ld_addr_i,
  input  wire logic [WORD_BITS-1:0] ld_a_i,
  input  wire logic [WORD_BITS-1:0] ld_b_i,
  input  wire logic [WORD_BITS-1:0] ld_r1_i,
  input  wire logic [AW-1:0]        part_addr_i,
  input  wire logic [WORD_BITS-1:0] part_data_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [WORD_BITS-1:0] a_rd_o,
  output logic      [WORD_BITS-1:0] b_rd_o,
  output logic      [WORD_BITS-1:0] r1_rd_o,
  output logic      [WORD_BITS-1:0] p_rd_o
);

  logic [WORD_BITS-1:0] a_mem  [MAX_WORDS];
  logic [WORD_BITS-1:0] b_mem  [MAX_WORDS];
  logic [WORD_BITS-1:0] r1_mem [MAX_WORDS];
  logic [WORD_BITS-1:0] p_mem  [MAX_WORDS];

  // operand loads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_we) begin
      a_mem[ld_addr_i]  <= ld_a_i;
      b_mem[ld_addr_i]  <= ld_b_i;
      r1_mem[ld_addr_i] <= ld_r1_i;
    end
  end

  // registered operand reads
  always_ff @(posedge clk_i) begin
    a_rd_o  <= a_mem[rd_addr_i];
    b_rd_o  <= b_mem[rd_addr_i];
    r1_rd_o <= r1_mem[rd_addr_i];
  end

  // partial word write
  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_we) begin
      p_mem[part_addr_i] <= part_data_i;
    end
  end

  // partial word read, forwarded when the same word is written this cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_we && (part_addr_i == rd_addr_i)) begin
      p_rd_o <= part_data_i;
    end else begin
      p_rd_o <= p_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmas_seq.sv =====
// sequencer that walks the words through the shared adder in two passes
`default_nettype none

module mmas_seq #(
  parameter int WORD_BITS = mmas_pkg::WordBitsDef,
  parameter int MAX_WORDS = mmas_pkg::MaxWordsDef,
  parameter int AW        = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire mmas_pkg::in_item_t            in_item_i,
  output logic                               in_ready_o,
  input  wire logic [mmas_pkg::CountW-1:0]   word_count_i,
  input  wire logic [WORD_BITS-1:0]          a_rd_i,
  input  wire logic [WORD_BITS-1:0]          b_rd_i,
  input  wire logic [WORD_BITS-1:0]          r1_rd_i,
  input  wire logic [WORD_BITS-1:0]          p_rd_i,
  input  wire logic [WORD_BITS-1:0]          alu_word_i,
  input  wire logic [1:0]                    alu_cnt_i,
  output logic      [WORD_BITS-1:0]          alu_x_o,
  output logic      [WORD_BITS-1:0]          alu_y_o,
  output logic      [WORD_BITS-1:0]          alu_z_o,
  output logic      [1:0]                    alu_cin_o,
  output logic                               alu_sub_o,
  output mmas_pkg::mem_ctrl_t                ctrl_o,
  output logic      [AW-1:0]                 ld_addr_o,
  output logic      [AW-1:0]                 rd_addr_o,
  output logic      [AW-1:0]                 part_addr_o,
  input  wire logic                          out_free_i,
  output logic                               out_load_o,
  output mmas_pkg::out_item_t                out_item_o
);

  mmas_pkg::state_e state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    last_q, last_d;
  logic             sub_q, sub_d;
  logic             m1_q, m1_d;
  logic             mask_q, mask_d;
  logic [1:0]       carry_q, carry_d;

  logic             accept;
  logic             is_run;
  logic             is_sub;
  logic [6:0]       n_words;
  logic             run_go;
  logic             at_last;
  logic [AW-1:0]    idx_inc;

  // decode of the accepted request
  always_comb begin
    accept = in_valid_i && in_ready_o;
    is_run = 1'b0;
    is_sub = 1'b0;
    unique case (mmas_pkg::action_e'(in_item_i.action))
      mmas_pkg::ACT_ADD: begin
        is_run = 1'b1;
      end
      mmas_pkg::ACT_SUB: begin
        is_run = 1'b1;
        is_sub = 1'b1;
      end
      default: begin
        is_run = 1'b0;
      end
    endcase
    if (32'(word_count_i) > MAX_WORDS) begin
      n_words = 7'(MAX_WORDS);
    end else begin
      n_words = 7'(word_count_i);
    end
    run_go  = accept && is_run && (n_words != 7'd0);
    at_last = (idx_q == last_q);
    idx_inc = idx_q + AW'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmas_pkg::ST_IDLE: begin
        if (run_go) begin
          state_d = mmas_pkg::ST_TOP;
        end
      end
      mmas_pkg::ST_TOP: begin
        state_d = mmas_pkg::ST_PASS1;
      end
      mmas_pkg::ST_PASS1: begin
        if (at_last) begin
          state_d = mmas_pkg::ST_PASS2;
        end
      end
      mmas_pkg::ST_PASS2: begin
        if (out_free_i && at_last) begin
          state_d = mmas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mmas_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs: handshake, memory control and adder operands
  always_comb begin
    in_ready_o     = (state_q == mmas_pkg::ST_IDLE);
    ctrl_o.load_we = accept && (mmas_pkg::action_e'(in_item_i.action) == mmas_pkg::ACT_LOAD)
                     && (32'(in_item_i.word_index) < MAX_WORDS);
    ctrl_o.part_we = 1'b0;
    ld_addr_o      = AW'(in_item_i.word_index);
    part_addr_o    = idx_q;
    rd_addr_o      = '0;
    alu_x_o        = a_rd_i;
    alu_y_o        = b_rd_i;
    alu_z_o        = '0;
    alu_cin_o      = carry_q;
    alu_sub_o      = sub_q;
    out_load_o     = 1'b0;
    unique case (state_q)
      mmas_pkg::ST_IDLE: begin
        // fetch the top words for the first mask
        rd_addr_o = AW'(n_words - 7'd1);
      end
      mmas_pkg::ST_TOP: begin
        alu_cin_o = 2'd0;
        rd_addr_o = '0;
      end
      mmas_pkg::ST_PASS1: begin
        alu_z_o        = m1_q ? r1_rd_i : '0;
        ctrl_o.part_we = 1'b1;
        rd_addr_o      = at_last ? '0 : idx_inc;
      end
      mmas_pkg::ST_PASS2: begin
        alu_x_o    = p_rd_i;
        alu_y_o    = '0;
        alu_z_o    = mask_q ? r1_rd_i : '0;
        out_load_o = out_free_i;
        // hold the read address while the output register is full
        if (out_free_i && !at_last) begin
          rd_addr_o = idx_inc;
        end else begin
          rd_addr_o = idx_q;
        end
      end
      default: begin
        rd_addr_o = '0;
      end
    endcase
    out_item_o.result_word  = mmas_pkg::FieldWordW'(alu_word_i);
    out_item_o.result_index = mmas_pkg::IndexW'(idx_q);
    out_item_o.last         = at_last;
  end

  // word index, masks and running carry
  always_comb begin
    idx_d   = idx_q;
    last_d  = last_q;
    sub_d   = sub_q;
    m1_d    = m1_q;
    mask_d  = mask_q;
    carry_d = carry_q;
    unique case (state_q)
      mmas_pkg::ST_IDLE: begin
        if (run_go) begin
          sub_d  = is_sub;
          last_d = AW'(n_words - 7'd1);
        end
      end
      mmas_pkg::ST_TOP: begin
        m1_d    = alu_cnt_i[0];
        carry_d = 2'd0;
        idx_d   = '0;
      end
      mmas_pkg::ST_PASS1: begin
        if (at_last) begin
          mask_d  = alu_cnt_i[0] ^ m1_q;
          carry_d = 2'd0;
          idx_d   = '0;
        end else begin
          carry_d = alu_cnt_i;
          idx_d   = idx_inc;
        end
      end
      mmas_pkg::ST_PASS2: begin
        if (out_free_i) begin
          carry_d = alu_cnt_i;
          idx_d   = idx_inc;
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmas_pkg::ST_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
      sub_q   <= 1'b0;
      m1_q    <= 1'b0;
      mask_q  <= 1'b0;
      carry_q <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      sub_q   <= sub_d;
      m1_q    <= m1_d;
      mask_q  <= mask_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/montgomery_modular_add_sub_unit.sv =====
// top level of the word-serial montgomery modular add/sub unit
//
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one request at a time.
// A load request writes one word of A, B and R1 at word_index and gives no
// result. An add or subtract request reads word_count words (capped at
// MAX_WORDS) and returns one result word per word, least significant first,
// with last set on the top word. In a run the request cycle fetches the top
// words, the top state (ST_TOP) forms the first mask, then pass one and pass
// two each walk the words, all through one shared word adder. in_ready_o is
// low for the whole run. Results leave through an output register; while the
// receiver stalls pass two holds and waits, and a new request may be taken
// while the final word is still waiting.
// The word_count register is written on the configuration channel, which is
// always ready; the user must change it only while the unit is idle, and the
// block itself does not enforce this. Reset clears the sequencer, the masks
// and the output valid flag and sets word_count to 32. The word memories are
// not cleared and hold no data until they are loaded.
`default_nettype none

module montgomery_modular_add_sub_unit #(
  parameter int WORD_BITS = mmas_pkg::WordBitsDef,
  parameter int MAX_WORDS = mmas_pkg::MaxWordsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire mmas_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output mmas_pkg::out_item_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [mmas_pkg::CountW-1:0] cfg_data_i
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [mmas_pkg::CountW-1:0] word_count_q;
  logic                        out_valid_q;
  mmas_pkg::out_item_t         out_data_q;

  mmas_pkg::mem_ctrl_t  ctrl;
  logic [AW-1:0]        ld_addr;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        part_addr;
  logic [WORD_BITS-1:0] a_rd, b_rd, r1_rd, p_rd;
  logic [WORD_BITS-1:0] alu_x, alu_y, alu_z, alu_word;
  logic [1:0]           alu_cin, alu_cnt;
  logic                 alu_sub;
  logic                 out_free;
  logic                 out_load;
  mmas_pkg::out_item_t  out_item;

  // word count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= mmas_pkg::WordCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      word_count_q <= cfg_data_i;
    end
  end

  mmas_store #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW)
  ) u_store (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .ld_addr_i   (ld_addr),
    .ld_a_i      (WORD_BITS'(in_data_i.a_word)),
    .ld_b_i      (WORD_BITS'(in_data_i.b_word)),
    .ld_r1_i     (WORD_BITS'(in_data_i.r1_word)),
    .part_addr_i (part_addr),
    .part_data_i (alu_word),
    .rd_addr_i   (rd_addr),
    .a_rd_o      (a_rd),
    .b_rd_o      (b_rd),
    .r1_rd_o     (r1_rd),
    .p_rd_o      (p_rd)
  );

  mmas_alu #(
    .WORD_BITS (WORD_BITS)
  ) u_alu (
    .x_i    (alu_x),
    .y_i    (alu_y),
    .z_i    (alu_z),
    .cin_i  (alu_cin),
    .sub_i  (alu_sub),
    .word_o (alu_word),
    .cnt_o  (alu_cnt)
  );

  mmas_seq #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS),
    .AW        (AW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .word_count_i (word_count_q),
    .a_rd_i       (a_rd),
    .b_rd_i       (b_rd),
    .r1_rd_i      (r1_rd),
    .p_rd_i       (p_rd),
    .alu_word_i   (alu_word),
    .alu_cnt_i    (alu_cnt),
    .alu_x_o      (alu_x),
    .alu_y_o      (alu_y),
    .alu_z_o      (alu_z),
    .alu_cin_o    (alu_cin),
    .alu_sub_o    (alu_sub),
    .ctrl_o       (ctrl),
    .ld_addr_o    (ld_addr),
    .rd_addr_o    (rd_addr),
    .part_addr_o  (part_addr),
    .out_free_i   (out_free),
    .out_load_o   (out_load),
    .out_item_o   (out_item)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/mmas_checker.sv =====
// port checker of the modular add/sub unit and its bind
`default_nettype none

`include "montgomery_modular_add_sub_unit_defines.svh"

module mmas_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire mmas_pkg::in_item_t          in_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire mmas_pkg::out_item_t         out_data_o,
  input wire logic                        cfg_valid_i,
  input wire logic                        cfg_ready_o
);

  logic [mmas_pkg::IndexW-1:0] exp_idx_q;
  logic                        out_acc;
  logic                        in_acc;
  logic                        out_stall;
  logic                        in_stall;
  logic                        cfg_acc;

  assign out_acc   = out_valid_o && out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign in_stall  = in_valid_i && !in_ready_o;
  assign cfg_acc   = cfg_valid_i && cfg_ready_o;

  // expected index of the next result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_acc) begin
      exp_idx_q <= out_data_o.last ? '0 : (exp_idx_q + mmas_pkg::IndexW'(1));
    end
  end

  // a stalled result word holds
  `MMAS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // a waiting request holds
  `MMAS_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_data_i))

  // the unit only goes busy on an accepted request
  `MMAS_ASSERT_NEXT(a_busy_on_req, clk_i, rst_ni, in_ready_o && !in_acc, in_ready_o)

  // result words of a run count up from zero
  `MMAS_ASSERT_SAME(a_idx_order, clk_i, rst_ni, out_valid_o, out_data_o.result_index == exp_idx_q)

  // word count only changes while the unit is idle
  `MMAS_ASSERT_SAME(a_cfg_idle, clk_i, rst_ni, cfg_acc, in_ready_o)

endmodule

bind montgomery_modular_add_sub_unit mmas_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
